[sv/hbp_pkg.sv]
// Shared types and constants for the Huffman bit packer.
// No dependencies; imported by huffman_bit_packer and hbp_packer.
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

    // Fixed field widths
    localparam int BYTE_W    = 8;    // output byte
    localparam int PEND_W    = 7;    // leftover bits between items
    localparam int PCNT_W    = 3;    // width of a leftover count (0..7)
    localparam int SYM_W     = 8;    // data byte / table index
    localparam int SYM_COUNT = 256;  // code table entries
    localparam int CODE_W    = 32;   // code_word field
    localparam int CLEN_W    = 6;    // code_len field

    // Input item kinds, carried in tuser
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_cmd;

    // Sequencer states of the top level
    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } t_state;

    // Commands from the sequencer to the packer
    typedef struct packed {
        logic ld_code;   // append the table entry on the RAM read port
        logic ld_flush;  // pad the leftover bits out to one byte
    } t_pk_ctrl;

    // Status from the packer to the sequencer
    typedef struct packed {
        logic busy;        // whole bytes still waiting to go out
        logic pend_empty;  // no leftover bits held
    } t_pk_stat;

endpackage

`default_nettype wire

[sv/huffman_bit_packer.sv]
// Huffman encoder back end: code table in RAM, bit packer, byte stream out.
// Load writes a table entry. Encode accepts the symbol, reads its table entry and
// then emits each whole byte, one byte per cycle while the output is not stalled.
// Flush pads any leftover bits out to one byte and emits it.
// Results appear in the cycle after they are formed, through the output register.
// Reset clears leftover bits and the output slot; the code table is not cleared.
// Depends on hbp_pkg, hbp_ram, hbp_packer.
`timescale 1ns / 1ps
`default_nettype none

module huffman_bit_packer import hbp_pkg::*; #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // [7:0] symbol, [39:8] code_word, [45:40] code_len
    input  wire  [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] packed_byte
    output logic        m_axis_tlast    // last_of_run
);

    localparam int CAP_LEN = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
    localparam int WORD_W  = CAP_LEN;
    localparam int LEN_W   = $clog2(CAP_LEN + 1);
    localparam int ENTRY_W = LEN_W + WORD_W;

    t_state r_state, n_state;
    t_cmd   cmd;
    logic   accept;

    logic [SYM_W-1:0]  in_symbol;
    logic [CODE_W-1:0] in_code;
    logic [CLEN_W-1:0] in_len;
    logic [LEN_W-1:0]  cap_len;

    logic               ram_we;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    t_pk_ctrl pk_ctrl;
    t_pk_stat pk_stat;

    // input field unpacking
    assign cmd       = t_cmd'(s_axis_tuser);
    assign in_symbol = s_axis_tdata[7:0];
    assign in_code   = s_axis_tdata[39:8];
    assign in_len    = s_axis_tdata[45:40];
    assign cap_len   = (in_len > CLEN_W'(CAP_LEN)) ? LEN_W'(CAP_LEN) : in_len[LEN_W-1:0];

    assign s_axis_tready = (r_state == ST_IDLE) && !pk_stat.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // sequencer: next state, table access and packer commands
    always_comb begin
        n_state          = r_state;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        pk_ctrl.ld_code  = 1'b0;
        pk_ctrl.ld_flush = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_LOAD:   ram_we = 1'b1;
                        CMD_ENCODE: begin
                            ram_re  = 1'b1;
                            n_state = ST_LOOK;
                        end
                        CMD_FLUSH:  pk_ctrl.ld_flush = !pk_stat.pend_empty;
                        default:    ;
                    endcase
                end
            end
            ST_LOOK: begin
                pk_ctrl.ld_code = 1'b1;
                n_state         = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // code table: {length, code word}
    hbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYM_COUNT)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (in_symbol),
        .i_wdata ({cap_len, in_code[WORD_W-1:0]}),
        .o_rdata (ram_rdata)
    );

    hbp_packer #(
        .WORD_W (WORD_W),
        .LEN_W  (LEN_W)
    ) u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (pk_ctrl),
        .i_word  (ram_rdata[WORD_W-1:0]),
        .i_len   (ram_rdata[ENTRY_W-1:WORD_W]),
        .o_stat  (pk_stat),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    // an encode transfer is always followed by the table read cycle
    a_encode_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (cmd == CMD_ENCODE)) |=> (r_state == ST_LOOK))
        else $error("encode transfer not followed by table read");

    // the packer never has bytes to emit while a table read is outstanding
    a_no_emit_in_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pk_stat.busy |-> (r_state == ST_IDLE))
        else $error("packer busy during table read");

    // a flush with leftover bits leaves one byte to emit
    a_flush_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (cmd == CMD_FLUSH) && !pk_stat.pend_empty) |=> pk_stat.busy)
        else $error("flush with leftover bits produced no byte");

endmodule

`default_nettype wire

[sv/hbp_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_addr,
    input  wire [WIDTH-1:0]          i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/hbp_packer.sv]
// Bit accumulator and byte emitter of the Huffman bit packer.
// Depends on hbp_pkg (control/status structs, byte constants).
`timescale 1ns / 1ps
`default_nettype none

module hbp_packer import hbp_pkg::*; #(
    parameter int WORD_W = 32,
    parameter int LEN_W  = 6
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_pk_ctrl           i_ctrl,
    input  wire [WORD_W-1:0]   i_word,
    input  wire [LEN_W-1:0]    i_len,
    output t_pk_stat           o_stat,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [BYTE_W-1:0]  o_byte,
    output logic               o_last
);

    localparam int ACC_W = WORD_W + PEND_W;
    localparam int CNT_W = $clog2(ACC_W + 1);

    // Accumulator: right aligned, earliest bit highest, bits above r_cnt are zero.
    // While r_cnt < 8 it simply holds the leftover bits.
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;

    logic              have_byte;
    logic              fire;
    logic [CNT_W-1:0]  byte_sh;
    logic [WORD_W-1:0] word_m;
    logic [3:0]        flush_sh;

    assign have_byte = (r_cnt >= CNT_W'(BYTE_W));
    assign fire      = have_byte && (!r_out_valid || i_ready);
    assign byte_sh   = r_cnt - CNT_W'(BYTE_W);
    assign word_m    = i_word & ~({WORD_W{1'b1}} << i_len);
    assign flush_sh  = 4'(BYTE_W) - 4'(r_cnt[PCNT_W-1:0]);

    // next accumulator and output slot
    always_comb begin
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (fire) begin
            // top byte of the accumulator goes out, the rest stays masked
            n_out_valid = 1'b1;
            n_out_byte  = BYTE_W'(r_acc >> byte_sh);
            n_out_last  = (byte_sh < CNT_W'(BYTE_W));
            n_acc       = r_acc & ~({ACC_W{1'b1}} << byte_sh);
            n_cnt       = byte_sh;
        end else if (i_ctrl.ld_code) begin
            n_acc = (r_acc << i_len) | ACC_W'(word_m);
            n_cnt = r_cnt + CNT_W'(i_len);
        end else if (i_ctrl.ld_flush) begin
            n_acc = r_acc << flush_sh;
            n_cnt = CNT_W'(BYTE_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_stat.busy       = have_byte;
    assign o_stat.pend_empty = (r_cnt == '0);
    assign o_valid           = r_out_valid;
    assign o_byte            = r_out_byte;
    assign o_last            = r_out_last;

endmodule

`default_nettype wire
